// ===== rtl/ble_adv_sensor_record_parser_assert.svh =====
// Assertion macros for the parser RTL, included by bsrp_core.
`ifndef BLE_ADV_SENSOR_RECORD_PARSER_ASSERT_SVH
`define BLE_ADV_SENSOR_RECORD_PARSER_ASSERT_SVH

// Checked only while out of reset.
`define BSRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define BSRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/bsrp_pkg.sv =====
package bsrp_pkg;

  localparam logic [7:0]  MaxReportBytes = 8'd255;

  localparam logic [7:0]  AdTypeSvc16 = 8'h16;
  localparam logic [15:0] UuidSensor  = 16'hFCD2;

  localparam logic [7:0]  ObjBattery = 8'h01;
  localparam logic [7:0]  ObjTemp    = 8'h02;
  localparam logic [7:0]  ObjHumWord = 8'h03;
  localparam logic [7:0]  ObjVoltage = 8'h0C;
  localparam logic [7:0]  ObjMode    = 8'h0F;
  localparam logic [7:0]  ObjHumByte = 8'h2E;
  localparam logic [7:0]  ObjComp    = 8'h2F;

  localparam int unsigned MaskBatt  = 0;
  localparam int unsigned MaskTemp0 = 1;
  localparam int unsigned MaskTemp1 = 2;
  localparam int unsigned MaskTemp2 = 3;
  localparam int unsigned MaskHum   = 4;
  localparam int unsigned MaskHum1  = 5;
  localparam int unsigned MaskComp  = 6;
  localparam int unsigned MaskMode  = 7;

  typedef enum logic [11:0] {
    PhLen     = 12'b0000_0000_0001,
    PhType    = 12'b0000_0000_0010,
    PhSkip    = 12'b0000_0000_0100,
    PhUuidLo  = 12'b0000_0000_1000,
    PhUuidHi  = 12'b0000_0001_0000,
    PhHeader  = 12'b0000_0010_0000,
    PhId      = 12'b0000_0100_0000,
    PhVal1    = 12'b0000_1000_0000,
    PhValLo   = 12'b0001_0000_0000,
    PhValHi   = 12'b0010_0000_0000,
    PhObjSkip = 12'b0100_0000_0000,
    PhDone    = 12'b1000_0000_0000
  } bsrp_phase_e;

  typedef struct packed {
    logic               found;
    logic [7:0]         present_mask;
    logic [7:0]         battery_pct;
    logic signed [15:0] temp_now;
    logic signed [15:0] temp_hour_avg;
    logic signed [15:0] temp_four_hour_avg;
    logic signed [15:0] humidity_hundredths;
    logic [7:0]         humidity_hour_avg;
    logic [7:0]         comp_duty;
    logic [7:0]         mode_byte;
  } bsrp_result_t;

endpackage

// ===== rtl/bsrp_if.sv =====
interface bsrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] report_length;
  logic       last_byte;

  modport source (output valid, output data_byte, output report_length, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input report_length, input last_byte,
                  output ready);
endinterface

interface bsrp_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [7:0]         present_mask;
  logic [7:0]         battery_pct;
  logic signed [15:0] temp_now;
  logic signed [15:0] temp_hour_avg;
  logic signed [15:0] temp_four_hour_avg;
  logic signed [15:0] humidity_hundredths;
  logic [7:0]         humidity_hour_avg;
  logic [7:0]         comp_duty;
  logic [7:0]         mode_byte;

  modport source (output valid, output found, output present_mask, output battery_pct,
                  output temp_now, output temp_hour_avg, output temp_four_hour_avg,
                  output humidity_hundredths, output humidity_hour_avg,
                  output comp_duty, output mode_byte, input ready);
  modport sink   (input valid, input found, input present_mask, input battery_pct,
                  input temp_now, input temp_hour_avg, input temp_four_hour_avg,
                  input humidity_hundredths, input humidity_hour_avg,
                  input comp_duty, input mode_byte, output ready);
endinterface

// ===== rtl/ble_adv_sensor_record_parser.sv =====
// Channel | Dir | Payload
// in_i    | in  | data_byte[7:0], report_length[7:0], last_byte
// out_o   | out | found, present_mask, battery_pct, temps x3, humidity x2,
//         |     | comp_duty, mode_byte
// One byte per cycle unless the input stalls: input register, parser state update, result register.
// After the last byte is transferred, it waits in the input register and the result register then captures the result.
// The input stalls only when a last byte waits, the result register is full
// and out_o.ready is low.
// rst_ni clears the parser to await the first structure length.
module ble_adv_sensor_record_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  bsrp_in_if.sink       in_i,
  bsrp_out_if.source    out_o
);
  import bsrp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   data_q;
  logic [7:0]   len_q;
  logic         last_q;
  logic         out_valid_q;
  bsrp_result_t out_q;
  bsrp_result_t res;
  logic         out_free;
  logic         take;

  assign out_free   = !out_valid_q || out_o.ready;
  assign take       = in_valid_q && (!last_q || out_free);
  assign in_i.ready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= in_i.data_byte;
      len_q  <= in_i.report_length;
      last_q <= in_i.last_byte;
    end
  end

  bsrp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .data_i (data_q),
    .len_i  (len_q),
    .last_i (last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last_q) begin
      out_q <= res;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.found               = out_q.found;
  assign out_o.present_mask        = out_q.present_mask;
  assign out_o.battery_pct         = out_q.battery_pct;
  assign out_o.temp_now            = out_q.temp_now;
  assign out_o.temp_hour_avg       = out_q.temp_hour_avg;
  assign out_o.temp_four_hour_avg  = out_q.temp_four_hour_avg;
  assign out_o.humidity_hundredths = out_q.humidity_hundredths;
  assign out_o.humidity_hour_avg   = out_q.humidity_hour_avg;
  assign out_o.comp_duty           = out_q.comp_duty;
  assign out_o.mode_byte           = out_q.mode_byte;

endmodule

// ===== rtl/bsrp_core.sv =====
`include "ble_adv_sensor_record_parser_assert.svh"

module bsrp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [7:0]            data_i,
  input  logic [7:0]            len_i,
  input  logic                  last_i,
  output bsrp_pkg::bsrp_result_t res_o
);
  import bsrp_pkg::*;

  bsrp_phase_e  phase_q, phase_d;
  logic [7:0]   pos_q, pos_d;
  logic [7:0]   rem_q, rem_d;
  logic         svc_ok_q, svc_ok_d;
  logic [7:0]   cur_q, cur_d;
  logic [7:0]   hold_q, hold_d;
  logic [1:0]   tcnt_q, tcnt_d;
  logic         bhum_q, bhum_d;
  bsrp_result_t fields_q, fields_d;

  logic         active;
  logic [7:0]   rem_dec;
  logic [7:0]   hold_dec;
  logic [8:0]   pos_inc;
  logic [9:0]   struct_end;
  logic [15:0]  hum100;
  logic [15:0]  word_val;

  assign active = (len_i != 8'd0) && (len_i <= MaxReportBytes) && (pos_q < len_i) &&
                  (phase_q != PhDone);
  assign rem_dec    = (rem_q != 8'd0) ? rem_q - 8'd1 : 8'd0;
  assign hold_dec   = (hold_q != 8'd0) ? hold_q - 8'd1 : 8'd0;
  assign pos_inc    = {1'b0, pos_q} + 9'd1;
  assign struct_end = {2'b00, pos_q} + 10'd1 + {2'b00, data_i};
  assign hum100     = {8'h00, data_i} * 16'd100;
  assign word_val   = {data_i, hold_q};

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    rem_d    = rem_q;
    svc_ok_d = svc_ok_q;
    cur_d    = cur_q;
    hold_d   = hold_q;
    tcnt_d   = tcnt_q;
    bhum_d   = bhum_q;
    fields_d = fields_q;

    if (take_i && active) begin
      unique case (phase_q)
        PhLen: begin
          if (pos_inc >= {1'b0, len_i} || data_i == 8'd0 || struct_end > {2'b00, len_i}) begin
            phase_d = PhDone;
          end else begin
            rem_d    = data_i;
            svc_ok_d = (data_i >= 8'd4);
            phase_d  = PhType;
          end
        end
        PhType: begin
          rem_d = rem_dec;
          if (data_i == AdTypeSvc16 && svc_ok_q) begin
            phase_d = PhUuidLo;
          end else begin
            phase_d = (rem_dec != 8'd0) ? PhSkip : PhLen;
          end
        end
        PhSkip: begin
          rem_d = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_d = PhLen;
          end
        end
        PhUuidLo: begin
          rem_d   = rem_dec;
          hold_d  = data_i;
          phase_d = PhUuidHi;
        end
        PhUuidHi: begin
          rem_d = rem_dec;
          if (word_val == UuidSensor) begin
            fields_d.found = 1'b1;
            phase_d        = PhHeader;
          end else begin
            phase_d = (rem_dec != 8'd0) ? PhSkip : PhLen;
          end
        end
        PhHeader: begin
          rem_d   = rem_dec;
          phase_d = (rem_dec != 8'd0) ? PhId : PhDone;
        end
        PhId: begin
          rem_d   = rem_dec;
          cur_d   = data_i;
          phase_d = (rem_dec != 8'd0) ? PhId : PhDone;
          case (data_i) inside
            ObjBattery, ObjHumByte, ObjComp, ObjMode: begin
              if (rem_dec >= 8'd1) phase_d = PhVal1;
            end
            ObjTemp, ObjHumWord: begin
              if (rem_dec >= 8'd2) phase_d = PhValLo;
            end
            ObjVoltage: begin
              if (rem_dec >= 8'd1) begin
                hold_d  = (rem_dec >= 8'd2) ? 8'd2 : 8'd1;
                phase_d = PhObjSkip;
              end
            end
            default: begin
              if (rem_dec >= 8'd1) begin
                hold_d  = 8'd1;
                phase_d = PhObjSkip;
              end
            end
          endcase
        end
        PhVal1: begin
          rem_d   = rem_dec;
          phase_d = (rem_dec != 8'd0) ? PhId : PhDone;
          case (cur_q)
            ObjBattery: begin
              fields_d.battery_pct            = data_i;
              fields_d.present_mask[MaskBatt] = 1'b1;
            end
            ObjHumByte: begin
              if (!bhum_q) begin
                if (!fields_q.present_mask[MaskHum]) begin
                  fields_d.humidity_hundredths   = hum100;
                  fields_d.present_mask[MaskHum] = 1'b1;
                end
              end else begin
                fields_d.humidity_hour_avg      = data_i;
                fields_d.present_mask[MaskHum1] = 1'b1;
              end
              bhum_d = 1'b1;
            end
            ObjComp: begin
              fields_d.comp_duty              = data_i;
              fields_d.present_mask[MaskComp] = 1'b1;
            end
            ObjMode: begin
              fields_d.mode_byte              = data_i;
              fields_d.present_mask[MaskMode] = 1'b1;
            end
            default: ;
          endcase
        end
        PhValLo: begin
          rem_d   = rem_dec;
          hold_d  = data_i;
          phase_d = PhValHi;
        end
        PhValHi: begin
          rem_d   = rem_dec;
          phase_d = (rem_dec != 8'd0) ? PhId : PhDone;
          if (cur_q == ObjTemp) begin
            case (tcnt_q)
              2'd0: begin
                fields_d.temp_now                = word_val;
                fields_d.present_mask[MaskTemp0] = 1'b1;
              end
              2'd1: begin
                fields_d.temp_hour_avg           = word_val;
                fields_d.present_mask[MaskTemp1] = 1'b1;
              end
              default: begin
                fields_d.temp_four_hour_avg      = word_val;
                fields_d.present_mask[MaskTemp2] = 1'b1;
              end
            endcase
            if (tcnt_q < 2'd2) tcnt_d = tcnt_q + 2'd1;
          end else begin
            fields_d.humidity_hundredths   = word_val;
            fields_d.present_mask[MaskHum] = 1'b1;
          end
        end
        PhObjSkip: begin
          rem_d  = rem_dec;
          hold_d = hold_dec;
          if (rem_dec == 8'd0) begin
            phase_d = PhDone;
          end else if (hold_dec == 8'd0) begin
            phase_d = PhId;
          end
        end
        default: phase_d = PhDone;
      endcase
    end

    if (take_i && pos_q != 8'hFF) begin
      pos_d = pos_q + 8'd1;
    end
  end

  assign res_o = fields_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhLen;
      pos_q    <= '0;
      rem_q    <= '0;
      svc_ok_q <= 1'b0;
      cur_q    <= '0;
      hold_q   <= '0;
      tcnt_q   <= '0;
      bhum_q   <= 1'b0;
      fields_q <= '0;
    end else if (take_i && last_i) begin
      phase_q  <= PhLen;
      pos_q    <= '0;
      rem_q    <= '0;
      svc_ok_q <= 1'b0;
      cur_q    <= '0;
      hold_q   <= '0;
      tcnt_q   <= '0;
      bhum_q   <= 1'b0;
      fields_q <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      rem_q    <= rem_d;
      svc_ok_q <= svc_ok_d;
      cur_q    <= cur_d;
      hold_q   <= hold_d;
      tcnt_q   <= tcnt_d;
      bhum_q   <= bhum_d;
      fields_q <= fields_d;
    end
  end

  `BSRP_ASSERT(a_clear_after_last, take_i && last_i |=> phase_q == PhLen && !fields_q.found && pos_q == 8'd0, "state not cleared after report end")
  `BSRP_ASSERT_ALWAYS(a_mask_needs_found, fields_q.present_mask != 8'd0 |-> fields_q.found, "object decoded without lock")
  `BSRP_ASSERT(a_temp_order, fields_q.present_mask[MaskTemp2] |-> fields_q.present_mask[MaskTemp1] && fields_q.present_mask[MaskTemp0], "temperature slots out of order")
  `BSRP_ASSERT_ALWAYS(a_tcnt_sat, tcnt_q != 2'd3, "temperature count overflow")

endmodule
